/* hdl/suue_pkg.sv */
package suue_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } suue_in_t;

  typedef struct packed {
    logic [7:0] ufrag_byte;
    logic [1:0] status;
    logic       run_end;
  } suue_out_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ATTR   = 3'd1,
    PH_VALUE  = 3'd3,
    PH_FOUND  = 3'd4,
    PH_DONE   = 3'd5
  } walk_phase_t;

  // Prefix write port from the walker into the current buffer bank.
  typedef struct packed {
    logic       we;
    logic [7:0] data;
  } suue_wr_t;

  // Frame summary that the walker hands to the result side on the last byte.
  typedef struct packed {
    logic       fire;
    logic       run;
    logic [1:0] status;
  } suue_done_t;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam int CNT_W   = 17;
  localparam int START_W = 18;

  localparam logic [CNT_W-1:0]   COUNT_MAX  = 17'h1FFFF;
  localparam logic [CNT_W-1:0]   POS_LEN_HI = 17'd2;
  localparam logic [CNT_W-1:0]   POS_LEN_LO = 17'd3;
  localparam logic [CNT_W-1:0]   POS_HDR_LAST = 17'd19;
  localparam logic [CNT_W-1:0]   HDR_COUNT  = 17'd20;
  localparam logic [START_W-1:0] HDR_BYTES  = 18'd20;
  localparam logic [START_W-1:0] ATTR_HDR   = 18'd4;
  localparam logic [START_W-1:0] PAD_MASK   = 18'd3;
  localparam logic [START_W-1:0] IDX_TYPE_END = 18'd2;
  localparam logic [START_W-1:0] IDX_LAST   = 18'd3;
  localparam logic [15:0]        ATTR_USERNAME = 16'h0006;
  localparam logic [7:0]         COLON      = 8'h3A;

endpackage

/* hdl/suue_walk.sv */
module suue_walk #(
  parameter int MAX_UFRAG = 32,
  parameter int IW        = 5,
  parameter int PLW       = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  suue_pkg::suue_in_t  item,
  output suue_pkg::suue_wr_t  wr,
  output logic [IW-1:0]       wr_addr,
  output suue_pkg::suue_done_t done,
  output logic [PLW-1:0]      done_len
);
  import suue_pkg::*;

  localparam logic [PLW-1:0] PLEN_MAX  = PLW'(MAX_UFRAG);
  localparam logic [PLW-1:0] PLEN_OVER = PLW'(MAX_UFRAG + 1);

  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [15:0]        declared_length, declared_length_next;
  logic [START_W-1:0] attr_start, attr_start_next;
  logic [15:0]        attr_type_reg, attr_type_reg_next;
  logic [15:0]        attr_length_reg, attr_length_reg_next;
  walk_phase_t        walk_phase, walk_phase_next;
  logic [PLW-1:0]     prefix_length, prefix_length_next;
  logic               colon_seen, colon_seen_next;

  logic [START_W-1:0] pos, msg_end, idx, vend_cur, vend_new, step, start_cand;
  logic               none;

  always_comb begin
    byte_count_next      = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;
    declared_length_next = declared_length;
    attr_start_next      = attr_start;
    attr_type_reg_next   = attr_type_reg;
    attr_length_reg_next = attr_length_reg;
    walk_phase_next      = walk_phase;
    prefix_length_next   = prefix_length;
    colon_seen_next      = colon_seen;
    wr.we                = 1'b0;
    wr.data              = item.rx_byte;

    pos      = START_W'(byte_count);
    msg_end  = HDR_BYTES + START_W'(declared_length);
    idx      = pos - attr_start;
    vend_cur = attr_start + ATTR_HDR + START_W'(attr_length_reg);
    vend_new = vend_cur;
    step     = '0;
    start_cand = attr_start;

    unique case (walk_phase)
      PH_HEADER: begin
        if (byte_count == POS_LEN_HI) begin
          declared_length_next = {item.rx_byte, 8'h00};
        end else if (byte_count == POS_LEN_LO) begin
          declared_length_next = declared_length | {8'h00, item.rx_byte};
        end else if (byte_count == POS_HDR_LAST) begin
          attr_start_next = HDR_BYTES;
          walk_phase_next = (HDR_BYTES + ATTR_HDR > msg_end) ? PH_DONE : PH_ATTR;
        end
      end
      PH_ATTR: begin
        if (pos >= attr_start) begin
          if (idx < IDX_TYPE_END) begin
            attr_type_reg_next = {attr_type_reg[7:0], item.rx_byte};
          end else begin
            attr_length_reg_next = {attr_length_reg[7:0], item.rx_byte};
          end
          vend_new   = attr_start + ATTR_HDR + START_W'(attr_length_reg_next);
          step       = (START_W'(attr_length_reg_next) + PAD_MASK) & ~PAD_MASK;
          start_cand = attr_start + ATTR_HDR + step;
          if (idx == IDX_LAST) begin
            if (attr_type_reg_next == ATTR_USERNAME) begin
              if (vend_new > msg_end) begin
                walk_phase_next = PH_DONE;
              end else if (attr_length_reg_next == 16'h0000) begin
                walk_phase_next = PH_FOUND;
              end else begin
                walk_phase_next = PH_VALUE;
              end
            end else begin
              attr_start_next = start_cand;
              walk_phase_next = (start_cand + ATTR_HDR > msg_end) ? PH_DONE : PH_ATTR;
            end
          end
        end
      end
      PH_VALUE: begin
        if (!colon_seen) begin
          if (item.rx_byte == COLON) begin
            colon_seen_next = 1'b1;
          end else if (prefix_length < PLEN_MAX) begin
            wr.we              = en;
            prefix_length_next = prefix_length + 1'b1;
          end else begin
            prefix_length_next = PLEN_OVER;
          end
        end
        if (pos + 1'b1 >= vend_cur) begin
          walk_phase_next = PH_FOUND;
        end
      end
      default: begin
      end
    endcase

    none = (byte_count_next < HDR_COUNT) || (walk_phase_next != PH_FOUND) ||
           !colon_seen_next || (prefix_length_next == '0);
    done.fire = en && item.frame_end;
    done.run  = !none && (prefix_length_next <= PLEN_MAX);
    priority if (none) begin
      done.status = ST_NONE;
    end else if (prefix_length_next > PLEN_MAX) begin
      done.status = ST_LONG;
    end else begin
      done.status = ST_FOUND;
    end
  end

  assign wr_addr  = prefix_length[IW-1:0];
  assign done_len = prefix_length_next;

  always_ff @(posedge clk) begin
    if (rst || (en && item.frame_end)) begin
      byte_count      <= '0;
      declared_length <= '0;
      attr_start      <= HDR_BYTES;
      attr_type_reg   <= '0;
      attr_length_reg <= '0;
      walk_phase      <= PH_HEADER;
      prefix_length   <= '0;
      colon_seen      <= 1'b0;
    end else if (en) begin
      byte_count      <= byte_count_next;
      declared_length <= declared_length_next;
      attr_start      <= attr_start_next;
      attr_type_reg   <= attr_type_reg_next;
      attr_length_reg <= attr_length_reg_next;
      walk_phase      <= walk_phase_next;
      prefix_length   <= prefix_length_next;
      colon_seen      <= colon_seen_next;
    end
  end

endmodule

/* hdl/stun_username_ufrag_extractor.sv */
// A frame's first result is registered in the input, run and output registers in turn.
// Throughput: one input item per cycle while data_stall is low; one result per cycle
// within a run while ufrag_stall is low, and an idle output between runs.
// A frame's last item waits in the input register while the previous frame's run of up to
// MAX_UFRAG results is still draining; the prefix buffer is double banked for this.
// Reset is synchronous and active high; it clears the walk state and both handshakes.
module stun_username_ufrag_extractor #(
  parameter int MAX_UFRAG = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  suue_pkg::suue_in_t  data,
  output logic                ufrag_valid,
  input  logic                ufrag_stall,
  output suue_pkg::suue_out_t ufrag
);
  import suue_pkg::*;

  localparam int IW  = (MAX_UFRAG > 1) ? $clog2(MAX_UFRAG) : 1;
  localparam int PLW = $clog2(MAX_UFRAG + 2);

  logic           stg_valid;
  suue_in_t       stg;
  logic           adv;

  suue_wr_t       wr;
  logic [IW-1:0]  wr_addr;
  suue_done_t     done;
  logic [PLW-1:0] done_len;
  logic [PLW-1:0] len_m1;

  logic [7:0]     pbuf [2][MAX_UFRAG];
  logic           wb;

  logic           busy;
  logic           rd_bank;
  logic [IW-1:0]  rd_idx;
  logic [IW-1:0]  rd_last;
  logic           rd_run;
  logic [1:0]     rd_status;
  logic           emit;

  assign adv        = stg_valid && !(stg.frame_end && busy);
  assign data_stall = stg_valid && !adv;
  assign emit       = busy && (!ufrag_valid || !ufrag_stall);
  assign len_m1     = done_len - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (data_valid && !data_stall) begin
      stg_valid <= 1'b1;
    end else if (adv) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      stg <= data;
    end
  end

  suue_walk #(
    .MAX_UFRAG(MAX_UFRAG),
    .IW       (IW),
    .PLW      (PLW)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .item    (stg),
    .wr      (wr),
    .wr_addr (wr_addr),
    .done    (done),
    .done_len(done_len)
  );

  always_ff @(posedge clk) begin
    if (wr.we) begin
      pbuf[wb][wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb   <= 1'b0;
      busy <= 1'b0;
    end else if (done.fire) begin
      wb   <= !wb;
      busy <= 1'b1;
    end else if (emit && (!rd_run || rd_idx == rd_last)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.fire) begin
      rd_bank   <= wb;
      rd_idx    <= '0;
      rd_last   <= len_m1[IW-1:0];
      rd_run    <= done.run;
      rd_status <= done.status;
    end else if (emit) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ufrag_valid <= 1'b0;
    end else if (emit) begin
      ufrag_valid <= 1'b1;
    end else if (!ufrag_stall) begin
      ufrag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ufrag.ufrag_byte <= rd_run ? pbuf[rd_bank][rd_idx] : 8'h00;
      ufrag.status     <= rd_status;
      ufrag.run_end    <= !rd_run || (rd_idx == rd_last);
    end
  end

endmodule

/* hdl/suue_check.sv */
module suue_check (
  input logic                clk,
  input logic                rst,
  input logic                data_valid,
  input logic                data_stall,
  input suue_pkg::suue_in_t  data,
  input logic                ufrag_valid,
  input logic                ufrag_stall,
  input suue_pkg::suue_out_t ufrag
);
  import suue_pkg::*;

  // A status-only item carries no byte and closes its frame.
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    ufrag_valid && (ufrag.status != ST_FOUND) |-> ufrag.run_end && (ufrag.ufrag_byte == 8'h00))
    else $error("status-only item without run_end or with a nonzero byte");

  // A run of ufrag bytes is delivered without gaps until its last item.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    ufrag_valid && !ufrag_stall && (ufrag.status == ST_FOUND) && !ufrag.run_end
    |=> ufrag_valid && (ufrag.status == ST_FOUND))
    else $error("ufrag run broken before its last item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    ufrag_valid |-> (ufrag.status == ST_NONE) || (ufrag.status == ST_FOUND) ||
                    (ufrag.status == ST_LONG))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ufrag_valid && ufrag_stall |=> ufrag_valid && $stable(ufrag))
    else $error("stalled result item changed");

endmodule

bind stun_username_ufrag_extractor suue_check u_suue_check (.*);
